### rtl/core/rvcp_pkg.sv
// ----------------------------------------------------------------------------
// RTMP video chunk packetizer package
// Shared constants, the queue entry format and command kinds.
// ----------------------------------------------------------------------------
package rvcp_pkg;

   // Fixed sizes of the framing.
   localparam int HEADER_BYTES      = 21;
   localparam int STEP_W            = 5;
   localparam int POS_W             = 13;
   localparam int QUEUE_DEPTH_DFLT  = 4;

   // Chunk size limits, as log2 of the body size.
   localparam logic [3:0] LOG2_MIN  = 4'd4;
   localparam logic [3:0] LOG2_MAX  = 4'd12;

   // Register reset values.
   localparam logic [3:0]  RST_CHUNK_LOG2 = 4'd7;
   localparam logic [15:0] RST_TS_STEP    = 16'd40;
   localparam logic [31:0] RST_STREAM_ID  = 32'd1;

   // Header and separator byte codes.
   localparam logic [7:0] BYTE_CHUNK_FMT0  = 8'h05;
   localparam logic [7:0] BYTE_MSG_VIDEO   = 8'h09;
   localparam logic [7:0] BYTE_TAG_KEY     = 8'h17;
   localparam logic [7:0] BYTE_TAG_INTER   = 8'h27;
   localparam logic [7:0] BYTE_AVC_NALU    = 8'h01;
   localparam logic [7:0] BYTE_ZERO        = 8'h00;
   localparam logic [7:0] BYTE_CHUNK_FMT3  = 8'hC5;

   // Configuration register indexes.
   localparam logic [1:0] CSR_CHUNK_LOG2 = 2'd0;
   localparam logic [1:0] CSR_TS_STEP    = 2'd1;
   localparam logic [1:0] CSR_STREAM_ID  = 2'd2;

   // What the back end has to emit for one accepted payload byte.
   typedef enum logic [1:0] {
      KIND_HDR,   // message header, then the byte
      KIND_SEP,   // chunk separator, then the byte
      KIND_BYTE   // the byte alone
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic        last;
      logic        key;
      logic [23:0] timestamp;
      logic [23:0] msg_len;
      logic [23:0] frame_len;
   } entry_type;

endpackage

### rtl/core/rtmp_video_chunk_packetizer.sv
// ----------------------------------------------------------------------------
// RTMP video chunk packetizer
// Frames H.264 payload bytes as RTMP video messages split into chunks.
// ----------------------------------------------------------------------------
// Each payload byte is one input transaction; the output carries one byte of
// the RTMP stream per transaction. A byte inside a chunk goes out alone, a
// byte that opens a new chunk after a separator, and the first byte of a
// frame after the chunk header and the video tag header. The back end drives
// one byte a cycle into its output register while the output does not stall.
// A short command queue sits between the front end and the back end, so
// input keeps flowing until the queue fills while the header of a frame goes
// out. Frames before the first key frame are dropped without output. Write the
// configuration registers only while no frame is in flight.
// ----------------------------------------------------------------------------
module rtmp_video_chunk_packetizer
   import rvcp_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DFLT
) (
   input  logic        clock,
   input  logic        reset,
   // Input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_byte,
   input  logic        req_last_byte,
   input  logic        req_key_frame,
   input  logic [23:0] req_frame_len,
   // Result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_last,
   // Configuration port
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   logic [3:0]  chunk_log2_ff;
   logic [15:0] ts_step_ff;
   logic [31:0] stream_id_ff;
   logic [3:0]  eff_log2;

   logic        queue_full;
   logic        push;
   entry_type   push_entry;
   logic        pop;
   logic        head_valid;
   entry_type   head_entry;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_log2_ff <= RST_CHUNK_LOG2;
         ts_step_ff    <= RST_TS_STEP;
         stream_id_ff  <= RST_STREAM_ID;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CHUNK_LOG2: chunk_log2_ff <= csr_write_data[3:0];
            CSR_TS_STEP:    ts_step_ff    <= csr_write_data[15:0];
            CSR_STREAM_ID:  stream_id_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Clamp the chunk size to the supported range.
   always_comb begin
      if (chunk_log2_ff < LOG2_MIN) begin
         eff_log2 = LOG2_MIN;
      end else if (chunk_log2_ff > LOG2_MAX) begin
         eff_log2 = LOG2_MAX;
      end else begin
         eff_log2 = chunk_log2_ff;
      end
   end

   rvcp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_first_byte (req_first_byte),
      .req_last_byte  (req_last_byte),
      .req_key_frame  (req_key_frame),
      .req_frame_len  (req_frame_len),
      .chunk_log2     (eff_log2),
      .timestamp_step (ts_step_ff),
      .queue_full     (queue_full),
      .push           (push),
      .push_entry     (push_entry)
   );

   rvcp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   rvcp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_entry   (head_entry),
      .stream_id    (stream_id_ff),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule

### rtl/core/rvcp_queue.sv
// ----------------------------------------------------------------------------
// RTMP packetizer command queue
// Small first-in first-out buffer between the front and the back end.
// ----------------------------------------------------------------------------
module rvcp_queue
   import rvcp_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DFLT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          store_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = store_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### rtl/core/rvcp_front.sv
// ----------------------------------------------------------------------------
// RTMP packetizer front end
// Accepts payload bytes, tracks frame and chunk state and queues commands.
// ----------------------------------------------------------------------------
module rvcp_front
   import rvcp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_byte,
   input  logic        req_last_byte,
   input  logic        req_key_frame,
   input  logic [23:0] req_frame_len,
   input  logic [3:0]  chunk_log2,
   input  logic [15:0] timestamp_step,
   input  logic        queue_full,
   output logic        push,
   output entry_type   push_entry
);

   logic             started_ff, started_in;
   logic             dropping_ff, dropping_in;
   logic             in_frame_ff, in_frame_in;
   logic [23:0]      timestamp_ff, timestamp_in;
   logic [POS_W-1:0] pos_ff, pos_in;

   logic             accept;
   logic             emit;
   logic             sep;
   logic [POS_W-1:0] chunk_size;
   logic [24:0]      len_plus8;
   logic [23:0]      extra_chunks;
   logic [23:0]      msg_len;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // Chunk size and the message length field: len + 9 + (chunks - 1).
   assign chunk_size   = POS_W'(1) << chunk_log2;
   assign len_plus8    = {1'b0, req_frame_len} + 25'd8;
   assign extra_chunks = 24'(len_plus8 >> chunk_log2);
   assign msg_len      = req_frame_len + 24'd9 + extra_chunks;
   assign sep          = (pos_ff >= chunk_size);

   // Classify the transaction and work out the next frame state.
   always_comb begin
      started_in   = started_ff;
      dropping_in  = dropping_ff;
      in_frame_in  = in_frame_ff;
      timestamp_in = timestamp_ff;
      pos_in       = pos_ff;
      emit         = 1'b0;
      push_entry.kind      = KIND_BYTE;
      push_entry.data      = req_data_byte;
      push_entry.last      = req_last_byte;
      push_entry.key       = req_key_frame;
      push_entry.timestamp = timestamp_ff;
      push_entry.msg_len   = msg_len;
      push_entry.frame_len = req_frame_len;
      if (req_first_byte) begin
         dropping_in = 1'b0;
         in_frame_in = 1'b0;
         if (req_key_frame || started_ff) begin
            // The header leaves nine body bytes in the first chunk, always
            // fewer than the smallest chunk, so no separator follows it.
            started_in      = 1'b1;
            emit            = 1'b1;
            push_entry.kind = KIND_HDR;
            timestamp_in    = timestamp_ff + {8'd0, timestamp_step};
            pos_in          = POS_W'(10);
            in_frame_in     = !req_last_byte;
         end else begin
            dropping_in = !req_last_byte;
         end
      end else if (dropping_ff) begin
         if (req_last_byte) begin
            dropping_in = 1'b0;
         end
      end else if (in_frame_ff) begin
         emit            = 1'b1;
         push_entry.kind = sep ? KIND_SEP : KIND_BYTE;
         pos_in          = sep ? POS_W'(1) : pos_ff + 1'b1;
         if (req_last_byte) begin
            in_frame_in = 1'b0;
         end
      end
   end

   assign push = accept && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         dropping_ff  <= 1'b0;
         in_frame_ff  <= 1'b0;
         timestamp_ff <= '0;
         pos_ff       <= '0;
      end else if (accept) begin
         started_ff   <= started_in;
         dropping_ff  <= dropping_in;
         in_frame_ff  <= in_frame_in;
         timestamp_ff <= timestamp_in;
         pos_ff       <= pos_in;
      end
   end

endmodule

### rtl/core/rvcp_back.sv
// ----------------------------------------------------------------------------
// RTMP packetizer back end
// Expands queued commands into output bytes, one a cycle while not stalled.
// ----------------------------------------------------------------------------
module rvcp_back
   import rvcp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  entry_type   head_entry,
   input  logic [31:0] stream_id,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_last
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        byte_ff, byte_in;
   logic              last_ff, last_in;

   logic              free;
   logic              advance;
   logic              data_step;
   logic [7:0]        hdr_byte;

   assign free    = !rsp_valid_ff || !rsp_stall;
   assign advance = free && head_valid;

   // The payload byte goes out after the header or the separator.
   always_comb begin
      case (head_entry.kind)
         KIND_HDR: data_step = (step_ff == STEP_W'(HEADER_BYTES));
         KIND_SEP: data_step = (step_ff != '0);
         default:  data_step = 1'b1;
      endcase
   end

   // Header byte at the current position.
   always_comb begin
      case (step_ff)
         5'd0:    hdr_byte = BYTE_CHUNK_FMT0;
         5'd1:    hdr_byte = head_entry.timestamp[23:16];
         5'd2:    hdr_byte = head_entry.timestamp[15:8];
         5'd3:    hdr_byte = head_entry.timestamp[7:0];
         5'd4:    hdr_byte = head_entry.msg_len[23:16];
         5'd5:    hdr_byte = head_entry.msg_len[15:8];
         5'd6:    hdr_byte = head_entry.msg_len[7:0];
         5'd7:    hdr_byte = BYTE_MSG_VIDEO;
         5'd8:    hdr_byte = stream_id[31:24];
         5'd9:    hdr_byte = stream_id[23:16];
         5'd10:   hdr_byte = stream_id[15:8];
         5'd11:   hdr_byte = stream_id[7:0];
         5'd12:   hdr_byte = head_entry.key ? BYTE_TAG_KEY : BYTE_TAG_INTER;
         5'd13:   hdr_byte = BYTE_AVC_NALU;
         5'd18:   hdr_byte = head_entry.frame_len[23:16];
         5'd19:   hdr_byte = head_entry.frame_len[15:8];
         5'd20:   hdr_byte = head_entry.frame_len[7:0];
         default: hdr_byte = BYTE_ZERO;
      endcase
   end

   // Output register and step counter.
   always_comb begin
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      byte_in      = byte_ff;
      last_in      = last_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         if (data_step) begin
            byte_in = head_entry.data;
            last_in = head_entry.last;
            step_in = '0;
         end else begin
            byte_in = (head_entry.kind == KIND_SEP) ? BYTE_CHUNK_FMT3 : hdr_byte;
            last_in = 1'b0;
            step_in = step_ff + 1'b1;
         end
      end
   end

   assign pop          = advance && data_step;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_out_last = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

endmodule
